### src/nnsb_pkg.sv
// ----------------------------------------------------------------------------
// nnsb_pkg
// Shared constants, register indexes and the divider interface type.
// ----------------------------------------------------------------------------
package nnsb_pkg;

    localparam int SRC_PIXELS = 16384;
    localparam int MAX_DIM    = 2048;
    localparam int IDX_W      = $clog2(SRC_PIXELS);
    localparam int DIM_W      = $clog2(MAX_DIM) + 1;
    localparam int COORD_W    = $clog2(MAX_DIM);
    localparam int PROD_W     = COORD_W + DIM_W;
    localparam int COLOR_W    = 32;
    localparam int PITCH_W    = 14;
    localparam int OFFS_W     = 25;
    localparam int BYTES_PER_PIXEL = COLOR_W / 8;

    localparam logic [3:0] REG_SRC_WIDTH  = 4'd0;
    localparam logic [3:0] REG_SRC_HEIGHT = 4'd1;
    localparam logic [3:0] REG_DST_WIDTH  = 4'd2;
    localparam logic [3:0] REG_DST_HEIGHT = 4'd3;
    localparam logic [3:0] REG_DST_X      = 4'd4;
    localparam logic [3:0] REG_DST_Y      = 4'd5;
    localparam logic [3:0] REG_KEY_COLOR  = 4'd6;
    localparam logic [3:0] REG_LINE_PITCH = 4'd7;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

### src/nearest_neighbor_scaled_blit_unit.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_scaled_blit_unit
// Nearest-neighbor sprite scaler with color key over a source pixel memory.
// ----------------------------------------------------------------------------
// Usage: configure sizes, origin, key and pitch over APB while idle. Send
// beats on the s_ channel: tuser is the command (0 load, 1 draw). A load
// writes one source pixel into the 16384-word memory and yields no beat. A
// draw yields one m_ beat with the frame-buffer byte offset, color,
// write enable and bad-request flag.
// Sequence: a load writes the memory in its own state; a rejected draw goes
// straight to the output stage. A draw runs two serial dividers (row and
// column) in parallel, then an index multiply, a memory read and an output
// stage. One item is in flight: the next item is accepted only once the
// result is in the output register. A rejected draw skips the dividers.
// Reset: configuration and control registers return to their reset values, the memory is not cleared.
// Stall: the result is held in m_ until taken; the next item is still
// accepted and runs up to its own output stage, where it waits for the
// output register to free.
// ----------------------------------------------------------------------------
module nearest_neighbor_scaled_blit_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [13:0] load_index, [45:14] load_color, [56:46] dst_row, [67:57] dst_col
    input  logic [71:0] s_tdata,
    // [0] cmd
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [24:0] fb_offset, [56:25] pixel_color, [57] write_enable, [58] bad_request
    output logic [63:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_IDX   = 7'b0001000,
        ST_READ  = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_SEND  = 7'b1000000
    } state_t;

    localparam int DW = nnsb_pkg::DIM_W;
    localparam int CW = nnsb_pkg::COORD_W;

    state_t state_reg, state_next;

    logic [DW-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [CW-1:0] dst_x_reg, dst_y_reg;
    logic [31:0]   key_reg;
    logic [nnsb_pkg::PITCH_W-1:0] pitch_reg;

    logic [nnsb_pkg::COLOR_W-1:0] mem [nnsb_pkg::SRC_PIXELS];
    logic [nnsb_pkg::COLOR_W-1:0] rd_data_reg;

    logic [nnsb_pkg::IDX_W-1:0]   ld_idx_reg;
    logic [nnsb_pkg::COLOR_W-1:0] ld_color_reg;
    logic [CW-1:0]                row_reg, col_reg;
    logic [2*DW-1:0]              sidx_reg;
    logic [nnsb_pkg::OFFS_W-1:0]  offs_reg;
    logic [63:0]                  m_data_reg;
    logic                         m_valid_reg;
    logic                         bad_now;
    logic                         accept;
    logic                         out_free;

    nnsb_pkg::div_ctl_t row_ctl, col_ctl;
    logic [nnsb_pkg::PROD_W-1:0] row_q, col_q;
    logic                        wr_en;

    function automatic logic size_ok(input logic [DW-1:0] v);
        return (v != '0) && (v <= DW'(nnsb_pkg::MAX_DIM));
    endfunction

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= DW'(1);
            src_h_reg <= DW'(1);
            dst_w_reg <= DW'(1);
            dst_h_reg <= DW'(1);
            dst_x_reg <= '0;
            dst_y_reg <= '0;
            key_reg   <= '0;
            pitch_reg <= nnsb_pkg::PITCH_W'(4096);
        end else if (wr_en) begin
            unique case (paddr[4:2])
                nnsb_pkg::REG_SRC_WIDTH[2:0]:  src_w_reg <= pwdata[DW-1:0];
                nnsb_pkg::REG_SRC_HEIGHT[2:0]: src_h_reg <= pwdata[DW-1:0];
                nnsb_pkg::REG_DST_WIDTH[2:0]:  dst_w_reg <= pwdata[DW-1:0];
                nnsb_pkg::REG_DST_HEIGHT[2:0]: dst_h_reg <= pwdata[DW-1:0];
                nnsb_pkg::REG_DST_X[2:0]:      dst_x_reg <= pwdata[CW-1:0];
                nnsb_pkg::REG_DST_Y[2:0]:      dst_y_reg <= pwdata[CW-1:0];
                nnsb_pkg::REG_KEY_COLOR[2:0]:  key_reg   <= pwdata;
                nnsb_pkg::REG_LINE_PITCH[2:0]: pitch_reg <= pwdata[nnsb_pkg::PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            nnsb_pkg::REG_SRC_WIDTH[2:0]:  prdata = 32'(src_w_reg);
            nnsb_pkg::REG_SRC_HEIGHT[2:0]: prdata = 32'(src_h_reg);
            nnsb_pkg::REG_DST_WIDTH[2:0]:  prdata = 32'(dst_w_reg);
            nnsb_pkg::REG_DST_HEIGHT[2:0]: prdata = 32'(dst_h_reg);
            nnsb_pkg::REG_DST_X[2:0]:      prdata = 32'(dst_x_reg);
            nnsb_pkg::REG_DST_Y[2:0]:      prdata = 32'(dst_y_reg);
            nnsb_pkg::REG_KEY_COLOR[2:0]:  prdata = key_reg;
            default:                       prdata = 32'(pitch_reg);
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign bad_now = !size_ok(src_w_reg) || !size_ok(src_h_reg) ||
                     !size_ok(dst_w_reg) || !size_ok(dst_h_reg) ||
                     ({1'b0, s_tdata[56:46]} >= dst_h_reg) ||
                     ({1'b0, s_tdata[67:57]} >= dst_w_reg);

    assign row_ctl.start = accept && (s_tuser == nnsb_pkg::CMD_DRAW) && !bad_now;
    assign col_ctl.start = row_ctl.start;

    nnsb_div u_div_row (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (row_ctl.start),
        .dividend ({{DW{1'b0}}, s_tdata[56:46]} * {{CW{1'b0}}, src_h_reg}),
        .divisor  (dst_h_reg),
        .busy     (row_ctl.busy),
        .done     (row_ctl.done),
        .quotient (row_q)
    );

    nnsb_div u_div_col (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (col_ctl.start),
        .dividend ({{DW{1'b0}}, s_tdata[67:57]} * {{CW{1'b0}}, src_w_reg}),
        .divisor  (dst_w_reg),
        .busy     (col_ctl.busy),
        .done     (col_ctl.done),
        .quotient (col_q)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == nnsb_pkg::CMD_LOAD) state_next = ST_LOAD;
                    else if (bad_now)                  state_next = ST_SEND;
                    else                               state_next = ST_DIV;
                end
            end
            ST_LOAD: state_next = ST_IDLE;
            ST_DIV:  if (row_ctl.done) state_next = ST_IDX;
            ST_IDX:  state_next = ST_READ;
            ST_READ: state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            ST_SEND: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_OUT || state_reg == ST_SEND) && out_free)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ld_idx_reg   <= s_tdata[13:0];
            ld_color_reg <= s_tdata[45:14];
            row_reg      <= s_tdata[56:46];
            col_reg      <= s_tdata[67:57];
        end
        if (state_reg == ST_LOAD) mem[ld_idx_reg] <= ld_color_reg;
        if (state_reg == ST_DIV && row_ctl.done) begin
            sidx_reg <= {{DW{1'b0}}, row_q[DW-1:0]} * {{DW{1'b0}}, src_w_reg} +
                        {{DW{1'b0}}, col_q[DW-1:0]};
            offs_reg <= nnsb_pkg::OFFS_W'((dst_y_reg + 25'(row_reg)) * pitch_reg);
        end
        if (state_reg == ST_IDX) begin
            rd_data_reg <= mem[sidx_reg[nnsb_pkg::IDX_W-1:0]];
            offs_reg    <= offs_reg + nnsb_pkg::OFFS_W'(nnsb_pkg::BYTES_PER_PIXEL *
                           (25'(dst_x_reg) + 25'(col_reg)));
        end
        if (state_reg == ST_OUT && out_free) begin
            if (sidx_reg >= (2*DW)'(nnsb_pkg::SRC_PIXELS))
                m_data_reg <= {5'd0, 1'b1, 1'b0, 32'd0, 25'd0};
            else
                m_data_reg <= {5'd0, 1'b0, rd_data_reg != key_reg, rd_data_reg, offs_reg};
        end
        if (state_reg == ST_SEND && out_free) m_data_reg <= {5'd0, 1'b1, 1'b0, 32'd0, 25'd0};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_div_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_ctl.done == col_ctl.done) && (row_ctl.busy == col_ctl.busy))
        else $error("dividers out of step");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        row_ctl.busy |-> !s_tready) else $error("accept while dividing");
    a_bad_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[58]) |-> (m_tdata[57:0] == '0)) else $error("bad beat payload");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");

endmodule

### src/nnsb_div.sv
// ----------------------------------------------------------------------------
// nnsb_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnsb_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [nnsb_pkg::PROD_W-1:0]         dividend,
    input  logic [nnsb_pkg::DIM_W-1:0]          divisor,
    output logic                                busy,
    output logic                                done,
    output logic [nnsb_pkg::PROD_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(nnsb_pkg::PROD_W + 1);

    logic [nnsb_pkg::PROD_W-1:0] q_reg;
    logic [nnsb_pkg::DIM_W:0]    rem_reg;
    logic [nnsb_pkg::DIM_W-1:0]  dv_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [nnsb_pkg::DIM_W:0]    trial;
    logic [nnsb_pkg::DIM_W+1:0]  diff;

    always_comb begin
        trial = {rem_reg[nnsb_pkg::DIM_W-1:0], q_reg[nnsb_pkg::PROD_W-1]};
        diff  = {1'b0, trial} - {2'b00, dv_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(nnsb_pkg::PROD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dv_reg  <= divisor;
        end else if (busy_reg) begin
            if (!diff[nnsb_pkg::DIM_W+1]) begin
                rem_reg <= diff[nnsb_pkg::DIM_W:0];
                q_reg   <= {q_reg[nnsb_pkg::PROD_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial;
                q_reg   <= {q_reg[nnsb_pkg::PROD_W-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
